FILE: rtl/core/ppu_register_interface_unit_macros.svh
// ----------------------------------------------------------------------------
// PPU register interface unit assertion macros
// Property wrappers shared by the checker of the register interface unit.
// ----------------------------------------------------------------------------
`ifndef PPU_REGISTER_INTERFACE_UNIT_MACROS_SVH
`define PPU_REGISTER_INTERFACE_UNIT_MACROS_SVH

// same-cycle implication
`define PPU_RIU_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppu_riu assertion failed");

// next-cycle implication
`define PPU_RIU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppu_riu assertion failed");

`endif

FILE: rtl/core/ppu_riu_pkg.sv
// ----------------------------------------------------------------------------
// PPU register interface unit package
// Transfer payload types, operation and register codes, and address masks.
// ----------------------------------------------------------------------------
package ppu_riu_pkg;

   localparam int OAM_DEPTH = 256;
   localparam int PAL_DEPTH = 32;

   typedef enum logic [3:0] {
      FUNC_REG_READ   = 4'd0,
      FUNC_REG_WRITE  = 4'd1,
      FUNC_VBLANK     = 4'd2,
      FUNC_PRERENDER  = 4'd3,
      FUNC_INC_X      = 4'd4,
      FUNC_INC_Y      = 4'd5,
      FUNC_COPY_HORIZ = 4'd6,
      FUNC_COPY_VERT  = 4'd7,
      FUNC_SET_HIT    = 4'd8,
      FUNC_SET_OVF    = 4'd9
   } func_type;

   typedef enum logic [2:0] {
      REG_CTRL     = 3'd0,
      REG_MASK     = 3'd1,
      REG_STATUS   = 3'd2,
      REG_OAM_ADDR = 3'd3,
      REG_OAM_DATA = 3'd4,
      REG_SCROLL   = 3'd5,
      REG_ADDR     = 3'd6,
      REG_DATA     = 3'd7
   } reg_index_type;

   localparam logic [13:0] PAL_BASE   = 14'h3F00;
   localparam logic [14:0] COPY_HMASK = 15'h041F;
   localparam logic [14:0] COPY_VMASK = 15'h7BE0;
   localparam logic [7:0]  GRAY_MASK  = 8'h30;

   typedef struct packed {
      logic [3:0] func;
      logic [2:0] reg_index;
      logic [7:0] write_data;
      logic [7:0] vram_rdata;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [13:0] vram_addr;
      logic        vram_write;
      logic [7:0]  vram_wdata;
      logic        nmi;
      logic [14:0] scroll_addr;
      logic [2:0]  fine_scroll_x;
      logic [7:0]  ctrl_value;
      logic [7:0]  mask_value;
   } rsp_type;

endpackage

FILE: rtl/core/ppu_riu_req_if.sv
// ----------------------------------------------------------------------------
// PPU register interface request channel
// Valid/ready channel carrying register accesses and renderer events.
// ----------------------------------------------------------------------------
interface ppu_riu_req_if;
   logic                  valid;
   logic                  ready;
   ppu_riu_pkg::req_type  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/ppu_riu_rsp_if.sv
// ----------------------------------------------------------------------------
// PPU register interface response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface ppu_riu_rsp_if;
   logic                  valid;
   logic                  ready;
   ppu_riu_pkg::rsp_type  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/ppu_register_interface_unit.sv
// ----------------------------------------------------------------------------
// PPU register interface unit
// CPU register file, object and palette memories and scroll address logic.
// ----------------------------------------------------------------------------
// One request is taken per clock, back to back, unless a response held at
// the output stalls the stage register. At the transfer the request enters
// the stage register; its response moves on into the output register when
// that register is free. The extra stage comes from the registered read of
// the object and palette memories; the scalar registers update at the
// request transfer, the read buffer when the item moves into the output
// register and the memory byte is known. Object and palette entries carry
// valid bits cleared by reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module ppu_register_interface_unit (
   input  logic              clock,
   input  logic              reset,
   ppu_riu_req_if.sink       req_port,
   ppu_riu_rsp_if.source     rsp_port
);

   typedef struct packed {
      logic                 rd_oam;
      logic                 rd_pal;
      logic                 rd_vram;
      logic                 gray;
      logic [7:0]           ext_byte;
      ppu_riu_pkg::rsp_type rsp;
   } stage_type;

   function automatic logic [4:0] pal_slot(input logic [4:0] a);
      logic [4:0] s;
      s = a;
      if (a[4] && (a[1:0] == 2'b00)) begin
         s = {1'b0, a[3:0]};
      end
      return s;
   endfunction

   logic [7:0]  ctrl_ff, ctrl_in;
   logic [7:0]  mask_ff, mask_in;
   logic [2:0]  status_ff, status_in;
   logic [7:0]  oam_index_ff, oam_index_in;
   logic [14:0] v_ff, v_in;
   logic [14:0] t_ff, t_in;
   logic        toggle_ff, toggle_in;
   logic [2:0]  fine_x_ff, fine_x_in;
   logic [7:0]  read_buffer_ff, read_buffer_in;

   logic [7:0]  oam_mem [ppu_riu_pkg::OAM_DEPTH];
   logic [ppu_riu_pkg::OAM_DEPTH-1:0] oam_valid_ff;
   logic [7:0]  oam_rdata_ff;
   logic        oam_rvalid_ff;
   logic [7:0]  pal_mem [ppu_riu_pkg::PAL_DEPTH];
   logic [ppu_riu_pkg::PAL_DEPTH-1:0] pal_valid_ff;
   logic [7:0]  pal_rdata_ff;
   logic        pal_rvalid_ff;

   logic        s1_valid_ff, s1_valid_in;
   stage_type   s1_ff, s1_in;
   logic        rsp_valid_ff, rsp_valid_in;
   ppu_riu_pkg::rsp_type rsp_ff, rsp_in;

   logic        accept, s1_adv, req_ready;
   logic        oam_we, pal_we;
   logic [13:0] v_low;
   logic        is_pal;
   logic [4:0]  pal_addr;
   logic [14:0] v_adv;
   logic [4:0]  coarse_y;
   ppu_riu_pkg::req_type req;
   logic [7:0]  oam_byte, pal_byte;

   assign req      = req_port.data;
   assign s1_adv   = s1_valid_ff && (!rsp_valid_ff || rsp_port.ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept   = req_port.valid && req_ready;
   assign req_port.ready = req_ready;

   assign v_low    = v_ff[13:0];
   assign is_pal   = (v_low >= ppu_riu_pkg::PAL_BASE);
   assign pal_addr = pal_slot(v_low[4:0]);
   assign v_adv    = v_ff + (ctrl_ff[2] ? 15'd32 : 15'd1);
   assign coarse_y = v_ff[9:5];

   // request stage: scalar state update and memory access issue
   always_comb begin
      ctrl_in      = ctrl_ff;
      mask_in      = mask_ff;
      status_in    = status_ff;
      oam_index_in = oam_index_ff;
      v_in         = v_ff;
      t_in         = t_ff;
      toggle_in    = toggle_ff;
      fine_x_in    = fine_x_ff;
      oam_we       = 1'b0;
      pal_we       = 1'b0;
      s1_in        = '0;
      s1_in.gray   = mask_ff[0];
      s1_in.ext_byte = req.vram_rdata;

      case (req.func)
         ppu_riu_pkg::FUNC_REG_READ: begin
            case (req.reg_index)
               ppu_riu_pkg::REG_STATUS: begin
                  s1_in.rsp.read_data = {status_ff, 5'b0};
                  status_in[2] = 1'b0;
                  toggle_in    = 1'b0;
               end
               ppu_riu_pkg::REG_OAM_DATA: begin
                  s1_in.rd_oam = 1'b1;
               end
               ppu_riu_pkg::REG_DATA: begin
                  s1_in.rsp.vram_addr = v_low;
                  s1_in.rd_pal  = is_pal;
                  s1_in.rd_vram = !is_pal;
                  v_in = v_adv;
               end
               default: begin
               end
            endcase
         end
         ppu_riu_pkg::FUNC_REG_WRITE: begin
            case (req.reg_index)
               ppu_riu_pkg::REG_CTRL: begin
                  ctrl_in       = req.write_data;
                  t_in[11:10]   = req.write_data[1:0];
               end
               ppu_riu_pkg::REG_MASK: begin
                  mask_in = req.write_data;
               end
               ppu_riu_pkg::REG_OAM_ADDR: begin
                  oam_index_in = req.write_data;
               end
               ppu_riu_pkg::REG_OAM_DATA: begin
                  oam_we       = 1'b1;
                  oam_index_in = oam_index_ff + 8'd1;
               end
               ppu_riu_pkg::REG_SCROLL: begin
                  if (!toggle_ff) begin
                     t_in[4:0] = req.write_data[7:3];
                     fine_x_in = req.write_data[2:0];
                  end else begin
                     t_in[9:5]   = req.write_data[7:3];
                     t_in[14:12] = req.write_data[2:0];
                  end
                  toggle_in = !toggle_ff;
               end
               ppu_riu_pkg::REG_ADDR: begin
                  if (!toggle_ff) begin
                     t_in[14:8] = {1'b0, req.write_data[5:0]};
                  end else begin
                     t_in[7:0] = req.write_data;
                     v_in      = {t_ff[14:8], req.write_data};
                  end
                  toggle_in = !toggle_ff;
               end
               ppu_riu_pkg::REG_DATA: begin
                  s1_in.rsp.vram_addr = v_low;
                  if (is_pal) begin
                     pal_we = 1'b1;
                  end else begin
                     s1_in.rsp.vram_write = 1'b1;
                     s1_in.rsp.vram_wdata = req.write_data;
                  end
                  v_in = v_adv;
               end
               default: begin
               end
            endcase
         end
         ppu_riu_pkg::FUNC_VBLANK: begin
            status_in[2]  = 1'b1;
            s1_in.rsp.nmi = ctrl_ff[7];
         end
         ppu_riu_pkg::FUNC_PRERENDER: begin
            status_in = 3'b000;
         end
         ppu_riu_pkg::FUNC_INC_X: begin
            if (v_ff[4:0] == 5'd31) begin
               v_in[4:0] = 5'd0;
               v_in[10]  = !v_ff[10];
            end else begin
               v_in[4:0] = v_ff[4:0] + 5'd1;
            end
         end
         ppu_riu_pkg::FUNC_INC_Y: begin
            if (v_ff[14:12] != 3'd7) begin
               v_in[14:12] = v_ff[14:12] + 3'd1;
            end else begin
               v_in[14:12] = 3'd0;
               if (coarse_y == 5'd29) begin
                  v_in[9:5] = 5'd0;
                  v_in[11]  = !v_ff[11];
               end else if (coarse_y == 5'd31) begin
                  v_in[9:5] = 5'd0;
               end else begin
                  v_in[9:5] = coarse_y + 5'd1;
               end
            end
         end
         ppu_riu_pkg::FUNC_COPY_HORIZ: begin
            v_in = (v_ff & ~ppu_riu_pkg::COPY_HMASK) | (t_ff & ppu_riu_pkg::COPY_HMASK);
         end
         ppu_riu_pkg::FUNC_COPY_VERT: begin
            v_in = (v_ff & ~ppu_riu_pkg::COPY_VMASK) | (t_ff & ppu_riu_pkg::COPY_VMASK);
         end
         ppu_riu_pkg::FUNC_SET_HIT: begin
            status_in[1] = 1'b1;
         end
         ppu_riu_pkg::FUNC_SET_OVF: begin
            status_in[0] = 1'b1;
         end
         default: begin
         end
      endcase

      s1_in.rsp.scroll_addr   = v_in;
      s1_in.rsp.fine_scroll_x = fine_x_in;
      s1_in.rsp.ctrl_value    = ctrl_in;
      s1_in.rsp.mask_value    = mask_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff      <= '0;
         mask_ff      <= '0;
         status_ff    <= '0;
         oam_index_ff <= '0;
         v_ff         <= '0;
         t_ff         <= '0;
         toggle_ff    <= 1'b0;
         fine_x_ff    <= '0;
      end else if (accept) begin
         ctrl_ff      <= ctrl_in;
         mask_ff      <= mask_in;
         status_ff    <= status_in;
         oam_index_ff <= oam_index_in;
         v_ff         <= v_in;
         t_ff         <= t_in;
         toggle_ff    <= toggle_in;
         fine_x_ff    <= fine_x_in;
      end
   end

   // object memory
   always_ff @(posedge clock) begin
      if (accept && oam_we) begin
         oam_mem[oam_index_ff] <= req.write_data;
      end
      if (accept) begin
         oam_rdata_ff  <= oam_mem[oam_index_ff];
         oam_rvalid_ff <= oam_valid_ff[oam_index_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oam_valid_ff <= '0;
      end else if (accept && oam_we) begin
         oam_valid_ff[oam_index_ff] <= 1'b1;
      end
   end

   // palette memory
   always_ff @(posedge clock) begin
      if (accept && pal_we) begin
         pal_mem[pal_addr] <= req.write_data;
      end
      if (accept) begin
         pal_rdata_ff  <= pal_mem[pal_addr];
         pal_rvalid_ff <= pal_valid_ff[pal_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_valid_ff <= '0;
      end else if (accept && pal_we) begin
         pal_valid_ff[pal_addr] <= 1'b1;
      end
   end

   // response stage: merge memory bytes and the read buffer
   always_comb begin
      oam_byte       = oam_rvalid_ff ? oam_rdata_ff : 8'd0;
      pal_byte       = pal_rvalid_ff ? pal_rdata_ff : 8'd0;
      if (s1_ff.gray) begin
         pal_byte = pal_byte & ppu_riu_pkg::GRAY_MASK;
      end
      rsp_in         = s1_ff.rsp;
      read_buffer_in = read_buffer_ff;
      if (s1_ff.rd_oam) begin
         rsp_in.read_data = oam_byte;
      end else if (s1_ff.rd_pal) begin
         rsp_in.read_data = pal_byte;
         read_buffer_in   = pal_byte;
      end else if (s1_ff.rd_vram) begin
         rsp_in.read_data = read_buffer_ff;
         read_buffer_in   = s1_ff.ext_byte;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         read_buffer_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            read_buffer_ff <= read_buffer_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.data  = rsp_ff;

endmodule

FILE: rtl/core/ppu_riu_checker.sv
// ----------------------------------------------------------------------------
// PPU register interface unit checker
// Port-level properties of the response channel, bound to the register interface unit.
// ----------------------------------------------------------------------------
`include "ppu_register_interface_unit_macros.svh"

module ppu_riu_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        vram_write,
   input logic [13:0] vram_addr,
   input logic [7:0]  vram_wdata,
   input logic        nmi,
   input logic [7:0]  ctrl_value
);

   `PPU_RIU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `PPU_RIU_ASSERT_IMPL(a_vram_write_range, clock, reset, rsp_valid && vram_write, vram_addr < ppu_riu_pkg::PAL_BASE)
   `PPU_RIU_ASSERT_IMPL(a_wdata_idle, clock, reset, rsp_valid && !vram_write, vram_wdata == 8'd0)
   `PPU_RIU_ASSERT_IMPL(a_nmi_enable, clock, reset, rsp_valid && nmi, ctrl_value[7])

endmodule

bind ppu_register_interface_unit ppu_riu_checker u_ppu_riu_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_port.valid),
   .rsp_ready  (rsp_port.ready),
   .vram_write (rsp_port.data.vram_write),
   .vram_addr  (rsp_port.data.vram_addr),
   .vram_wdata (rsp_port.data.vram_wdata),
   .nmi        (rsp_port.data.nmi),
   .ctrl_value (rsp_port.data.ctrl_value)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPU register interface unit testbench
// Drives register accesses and renderer events through the request channel
// while both channel sides idle and stall at random. Every response is checked
// field by field against a scoreboard fed by a cycle-free model of the register file,
// object and palette memories and scroll addresses, or by a typed directed row.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int         HALF_PERIOD   = 2;
   localparam int         RANDOM_ITEMS  = 1300;
   localparam int         PRESSURE_AT   = 600;
   localparam int         PRESSURE_LEN  = 80;
   localparam int         HOLD_CYCLES   = 200;
   localparam int         DRAIN_LIMIT   = 5000;
   localparam int         SETTLE_CYCLES = 8;
   localparam int         MAX_REPORTS   = 40;
   localparam int         TIMEOUT_NS    = 2_000_000;
   localparam int         STS_VBLANK    = 2;
   localparam int         STS_HIT       = 1;
   localparam int         STS_OVF       = 0;
   localparam logic [3:0] FUNC_UNUSED   = 4'd15;
   localparam logic [5:0] PAL_PAGE      = 6'h3F;
   localparam logic [7:0] Y_WRAP_NT     = 8'hEF;  // coarse Y 29, fine Y 7
   localparam logic [7:0] Y_WRAP_ATTR   = 8'hFF;  // coarse Y 31, fine Y 7

   typedef struct packed {
      logic [3:0] func;
      logic [2:0] reg_index;
      logic [7:0] write_data;
      logic [7:0] vram_rdata;
      logic       typed;
      logic [7:0] exp_read;
      logic       exp_nmi;
      logic [7:0] exp_ctrl;
   } dir_row_type;

   typedef struct packed {
      logic                 typed;
      ppu_riu_pkg::rsp_type rsp;
   } note_type;

   typedef enum logic [1:0] {RX_STEADY, RX_SPARSE, RX_PERIODIC, RX_COIN} rx_mode_type;

   localparam int DIR_COUNT = 25;
   localparam dir_row_type DIR_ROWS [0:DIR_COUNT-1] = '{
      '{ppu_riu_pkg::FUNC_REG_READ,   ppu_riu_pkg::REG_STATUS,
        8'h00, 8'hFF, 1'b1, 8'h00, 1'b0, 8'h00},
      '{ppu_riu_pkg::FUNC_REG_WRITE,  ppu_riu_pkg::REG_CTRL,
        8'hFF, 8'h00, 1'b1, 8'h00, 1'b0, 8'hFF},
      '{ppu_riu_pkg::FUNC_VBLANK,     ppu_riu_pkg::REG_CTRL,
        8'h00, 8'h00, 1'b1, 8'h00, 1'b1, 8'hFF},
      '{ppu_riu_pkg::FUNC_SET_HIT,    ppu_riu_pkg::REG_CTRL,
        8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{ppu_riu_pkg::FUNC_SET_OVF,    ppu_riu_pkg::REG_CTRL,
        8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{ppu_riu_pkg::FUNC_REG_READ,   ppu_riu_pkg::REG_STATUS,
        8'h00, 8'h00, 1'b1, 8'hE0, 1'b0, 8'hFF},
      '{ppu_riu_pkg::FUNC_PRERENDER,  ppu_riu_pkg::REG_CTRL,
        8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{ppu_riu_pkg::FUNC_REG_WRITE,  ppu_riu_pkg::REG_STATUS,
        8'hFF, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{ppu_riu_pkg::FUNC_REG_READ,   ppu_riu_pkg::REG_MASK,
        8'h00, 8'hFF, 1'b1, 8'h00, 1'b0, 8'hFF},
      '{ppu_riu_pkg::FUNC_REG_WRITE,  ppu_riu_pkg::REG_MASK,
        8'h01, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{ppu_riu_pkg::FUNC_REG_WRITE,  ppu_riu_pkg::REG_OAM_ADDR,
        8'hFF, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{ppu_riu_pkg::FUNC_REG_WRITE,  ppu_riu_pkg::REG_OAM_DATA,
        8'hAB, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{ppu_riu_pkg::FUNC_REG_WRITE,  ppu_riu_pkg::REG_OAM_ADDR,
        8'hFF, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{ppu_riu_pkg::FUNC_REG_READ,   ppu_riu_pkg::REG_OAM_DATA,
        8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{ppu_riu_pkg::FUNC_REG_WRITE,  ppu_riu_pkg::REG_SCROLL,
        8'hFF, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{ppu_riu_pkg::FUNC_REG_WRITE,  ppu_riu_pkg::REG_SCROLL,
        8'hFF, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{ppu_riu_pkg::FUNC_REG_WRITE,  ppu_riu_pkg::REG_ADDR,
        8'h3F, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{ppu_riu_pkg::FUNC_REG_WRITE,  ppu_riu_pkg::REG_ADDR,
        8'h10, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{ppu_riu_pkg::FUNC_REG_WRITE,  ppu_riu_pkg::REG_DATA,
        8'hFF, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{ppu_riu_pkg::FUNC_REG_READ,   ppu_riu_pkg::REG_DATA,
        8'h00, 8'h5A, 1'b0, 8'h00, 1'b0, 8'h00},
      '{ppu_riu_pkg::FUNC_INC_X,      ppu_riu_pkg::REG_CTRL,
        8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{ppu_riu_pkg::FUNC_INC_Y,      ppu_riu_pkg::REG_CTRL,
        8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{ppu_riu_pkg::FUNC_COPY_HORIZ, ppu_riu_pkg::REG_CTRL,
        8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{ppu_riu_pkg::FUNC_COPY_VERT,  ppu_riu_pkg::REG_CTRL,
        8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{FUNC_UNUSED,                  ppu_riu_pkg::REG_DATA,
        8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0, 8'h00}
   };

   logic clock = 1'b0;
   logic reset;
   logic hold_armed;

   ppu_riu_req_if req_if ();
   ppu_riu_rsp_if rsp_if ();

   ppu_register_interface_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   always #HALF_PERIOD clock = ~clock;

   // register file shadow
   logic [7:0]  ctrl_q;
   logic [7:0]  mask_q;
   logic [2:0]  status_q;
   logic [7:0]  oam_ptr;
   logic [7:0]  oam_mem [0:ppu_riu_pkg::OAM_DEPTH-1];
   logic [7:0]  pal_mem [0:ppu_riu_pkg::PAL_DEPTH-1];
   logic [14:0] v_addr;
   logic [14:0] t_addr;
   logic        latch_q;
   logic [2:0]  fine_x_q;
   logic [7:0]  rd_buf;

   note_type             note_q [$];
   ppu_riu_pkg::rsp_type expect_q [$];
   int      fail_count = 0;
   int      burst_left = 0;

   function automatic logic [4:0] pal_slot(logic [13:0] a);
      logic [4:0] s;
      s = a[4:0];
      if (s[4] && s[1:0] == 2'b00) s[4] = 1'b0;
      return s;
   endfunction

   function automatic void advance_data_addr();
      v_addr = v_addr + (ctrl_q[2] ? 15'd32 : 15'd1);
   endfunction

   function automatic ppu_riu_pkg::rsp_type predict_response(ppu_riu_pkg::req_type r);
      ppu_riu_pkg::rsp_type o;
      logic [13:0] a;
      logic [7:0]  p;
      logic [4:0]  yc;
      o = '0;
      a = v_addr[13:0];
      case (r.func)
         ppu_riu_pkg::FUNC_REG_READ: begin
            case (r.reg_index)
               ppu_riu_pkg::REG_STATUS: begin
                  o.read_data = {status_q, 5'b0};
                  status_q[STS_VBLANK] = 1'b0;
                  latch_q = 1'b0;
               end
               ppu_riu_pkg::REG_OAM_DATA: o.read_data = oam_mem[oam_ptr];
               ppu_riu_pkg::REG_DATA: begin
                  o.vram_addr = a;
                  o.read_data = rd_buf;
                  if (a >= ppu_riu_pkg::PAL_BASE) begin
                     p = pal_mem[pal_slot(a)];
                     if (mask_q[0]) p = p & ppu_riu_pkg::GRAY_MASK;
                     rd_buf = p;
                     o.read_data = p;
                  end else begin
                     rd_buf = r.vram_rdata;
                  end
                  advance_data_addr();
               end
               default: ;
            endcase
         end
         ppu_riu_pkg::FUNC_REG_WRITE: begin
            case (r.reg_index)
               ppu_riu_pkg::REG_CTRL: begin
                  ctrl_q = r.write_data;
                  t_addr[11:10] = r.write_data[1:0];
               end
               ppu_riu_pkg::REG_MASK:     mask_q = r.write_data;
               ppu_riu_pkg::REG_OAM_ADDR: oam_ptr = r.write_data;
               ppu_riu_pkg::REG_OAM_DATA: begin
                  oam_mem[oam_ptr] = r.write_data;
                  oam_ptr = oam_ptr + 8'd1;
               end
               ppu_riu_pkg::REG_SCROLL: begin
                  if (!latch_q) begin
                     t_addr[4:0] = r.write_data[7:3];
                     fine_x_q = r.write_data[2:0];
                  end else begin
                     t_addr[9:5] = r.write_data[7:3];
                     t_addr[14:12] = r.write_data[2:0];
                  end
                  latch_q = ~latch_q;
               end
               ppu_riu_pkg::REG_ADDR: begin
                  if (!latch_q) begin
                     t_addr[13:8] = r.write_data[5:0];
                     t_addr[14] = 1'b0;
                  end else begin
                     t_addr[7:0] = r.write_data;
                     v_addr = t_addr;
                  end
                  latch_q = ~latch_q;
               end
               ppu_riu_pkg::REG_DATA: begin
                  o.vram_addr = a;
                  if (a >= ppu_riu_pkg::PAL_BASE) begin
                     pal_mem[pal_slot(a)] = r.write_data;
                  end else begin
                     o.vram_write = 1'b1;
                     o.vram_wdata = r.write_data;
                  end
                  advance_data_addr();
               end
               default: ;
            endcase
         end
         ppu_riu_pkg::FUNC_VBLANK: begin
            status_q[STS_VBLANK] = 1'b1;
            o.nmi = ctrl_q[7];
         end
         ppu_riu_pkg::FUNC_PRERENDER: status_q = '0;
         ppu_riu_pkg::FUNC_INC_X: begin
            if (v_addr[4:0] == 5'd31) begin
               v_addr[4:0] = 5'd0;
               v_addr[10] = ~v_addr[10];
            end else begin
               v_addr[4:0] = v_addr[4:0] + 5'd1;
            end
         end
         ppu_riu_pkg::FUNC_INC_Y: begin
            if (v_addr[14:12] != 3'd7) begin
               v_addr[14:12] = v_addr[14:12] + 3'd1;
            end else begin
               v_addr[14:12] = 3'd0;
               yc = v_addr[9:5];
               if (yc == 5'd29) begin
                  yc = 5'd0;
                  v_addr[11] = ~v_addr[11];
               end else if (yc == 5'd31) begin
                  yc = 5'd0;
               end else begin
                  yc = yc + 5'd1;
               end
               v_addr[9:5] = yc;
            end
         end
         ppu_riu_pkg::FUNC_COPY_HORIZ: begin
            v_addr = (v_addr & ~ppu_riu_pkg::COPY_HMASK) |
                     (t_addr & ppu_riu_pkg::COPY_HMASK);
         end
         ppu_riu_pkg::FUNC_COPY_VERT: begin
            v_addr = (v_addr & ~ppu_riu_pkg::COPY_VMASK) |
                     (t_addr & ppu_riu_pkg::COPY_VMASK);
         end
         ppu_riu_pkg::FUNC_SET_HIT:    status_q[STS_HIT] = 1'b1;
         ppu_riu_pkg::FUNC_SET_OVF:    status_q[STS_OVF] = 1'b1;
         default: ;
      endcase
      o.scroll_addr   = v_addr;
      o.fine_scroll_x = fine_x_q;
      o.ctrl_value    = ctrl_q;
      o.mask_value    = mask_q;
      return o;
   endfunction

   task automatic compare_field(string what, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $display("%0t ns %s mismatch: expected %0h actual %0h", $time, what, want, got);
      end
   endtask

   // response side: shadow update, scoreboard, stall pattern
   rx_mode_type rx_mode = RX_STEADY;
   int       rx_tick = 0;
   int       hold_left = 0;
   logic     hold_done = 1'b0;

   always @(posedge clock) begin : response_side
      ppu_riu_pkg::rsp_type want;
      note_type             note;
      if (reset) begin
         ctrl_q   = '0;
         mask_q   = '0;
         status_q = '0;
         oam_ptr  = '0;
         v_addr   = '0;
         t_addr   = '0;
         latch_q  = 1'b0;
         fine_x_q = '0;
         rd_buf   = '0;
         for (int i = 0; i < ppu_riu_pkg::OAM_DEPTH; i++) oam_mem[i] = '0;
         for (int i = 0; i < ppu_riu_pkg::PAL_DEPTH; i++) pal_mem[i] = '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            note = note_q.pop_front();
            want = predict_response(req_if.data);
            expect_q.push_back(note.typed ? note.rsp : want);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expect_q.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t ns unexpected response: expected none actual %h",
                           $time, rsp_if.data);
            end else begin
               want = expect_q.pop_front();
               compare_field("read_data", 16'(want.read_data),
                             16'(rsp_if.data.read_data));
               compare_field("vram_addr", 16'(want.vram_addr),
                             16'(rsp_if.data.vram_addr));
               compare_field("vram_write", 16'(want.vram_write),
                             16'(rsp_if.data.vram_write));
               compare_field("vram_wdata", 16'(want.vram_wdata),
                             16'(rsp_if.data.vram_wdata));
               compare_field("nmi", 16'(want.nmi), 16'(rsp_if.data.nmi));
               compare_field("scroll_addr", 16'(want.scroll_addr),
                             16'(rsp_if.data.scroll_addr));
               compare_field("fine_scroll_x", 16'(want.fine_scroll_x),
                             16'(rsp_if.data.fine_scroll_x));
               compare_field("ctrl_value", 16'(want.ctrl_value),
                             16'(rsp_if.data.ctrl_value));
               compare_field("mask_value", 16'(want.mask_value),
                             16'(rsp_if.data.mask_value));
            end
         end
      end

      rx_tick++;
      if (rx_tick % 64 == 0) rx_mode = rx_mode_type'($urandom_range(0, 3));
      if (hold_left != 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (hold_armed && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_STEADY:   rsp_if.ready <= 1'b1;
            RX_SPARSE:   rsp_if.ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: rsp_if.ready <= rx_tick[2];
            default:     rsp_if.ready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   function automatic ppu_riu_pkg::req_type make_item(logic [3:0] f, logic [2:0] ri,
                                                       logic [7:0] wd);
      ppu_riu_pkg::req_type r;
      r.func       = f;
      r.reg_index  = ri;
      r.write_data = wd;
      r.vram_rdata = 8'($urandom);
      return r;
   endfunction

   // hold valid through a burst, drop it between bursts
   task automatic send_item(ppu_riu_pkg::req_type r, logic typed,
                            ppu_riu_pkg::rsp_type typed_rsp);
      if (burst_left == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end
      note_q.push_back({typed, typed_rsp});
      req_if.valid <= 1'b1;
      req_if.data  <= r;
      do @(posedge clock); while (!req_if.ready);
      burst_left--;
   endtask

   initial begin : stimulus
      ppu_riu_pkg::req_type seq [$];
      ppu_riu_pkg::req_type item;
      ppu_riu_pkg::rsp_type typed_rsp;
      logic [7:0] start;
      int       sent;
      int       pick;
      int       guard;
      logic     pressure_done;

      reset        <= 1'b1;
      hold_armed   <= 1'b0;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_COUNT; i++) begin
         item.func       = DIR_ROWS[i].func;
         item.reg_index  = DIR_ROWS[i].reg_index;
         item.write_data = DIR_ROWS[i].write_data;
         item.vram_rdata = DIR_ROWS[i].vram_rdata;
         typed_rsp            = '0;
         typed_rsp.read_data  = DIR_ROWS[i].exp_read;
         typed_rsp.nmi        = DIR_ROWS[i].exp_nmi;
         typed_rsp.ctrl_value = DIR_ROWS[i].exp_ctrl;
         send_item(item, DIR_ROWS[i].typed, typed_rsp);
      end

      sent = 0;
      pressure_done = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         if (!pressure_done && sent >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            hold_armed <= 1'b1;
            burst_left = PRESSURE_LEN;
         end
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            if ($urandom_range(0, 3) != 0)
               seq.push_back(make_item(ppu_riu_pkg::FUNC_REG_READ, ppu_riu_pkg::REG_STATUS,
                                       8'($urandom)));
            seq.push_back(make_item(ppu_riu_pkg::FUNC_REG_WRITE, ppu_riu_pkg::REG_ADDR,
                                    $urandom_range(0, 1) ? {2'($urandom), PAL_PAGE}
                                                         : 8'($urandom)));
            seq.push_back(make_item(ppu_riu_pkg::FUNC_REG_WRITE, ppu_riu_pkg::REG_ADDR,
                                    8'($urandom)));
            repeat ($urandom_range(1, 10))
               seq.push_back(make_item($urandom_range(0, 1) ? ppu_riu_pkg::FUNC_REG_WRITE
                                                            : ppu_riu_pkg::FUNC_REG_READ,
                                       ppu_riu_pkg::REG_DATA, 8'($urandom)));
         end else if (pick < 50) begin
            seq.push_back(make_item(ppu_riu_pkg::FUNC_REG_READ, ppu_riu_pkg::REG_STATUS,
                                    8'($urandom)));
            if ($urandom_range(0, 1))
               seq.push_back(make_item(ppu_riu_pkg::FUNC_REG_WRITE, ppu_riu_pkg::REG_CTRL,
                                       8'($urandom)));
            seq.push_back(make_item(ppu_riu_pkg::FUNC_REG_WRITE, ppu_riu_pkg::REG_SCROLL,
                                    8'($urandom)));
            case ($urandom_range(0, 3))
               0: seq.push_back(make_item(ppu_riu_pkg::FUNC_REG_WRITE,
                                          ppu_riu_pkg::REG_SCROLL, Y_WRAP_NT));
               1: seq.push_back(make_item(ppu_riu_pkg::FUNC_REG_WRITE,
                                          ppu_riu_pkg::REG_SCROLL, Y_WRAP_ATTR));
               default: seq.push_back(make_item(ppu_riu_pkg::FUNC_REG_WRITE,
                                                ppu_riu_pkg::REG_SCROLL, 8'($urandom)));
            endcase
            seq.push_back(make_item(ppu_riu_pkg::FUNC_COPY_VERT, 3'($urandom),
                                    8'($urandom)));
            repeat ($urandom_range(1, 6)) begin
               repeat ($urandom_range(0, 8))
                  seq.push_back(make_item(ppu_riu_pkg::FUNC_INC_X, 3'($urandom),
                                          8'($urandom)));
               seq.push_back(make_item(ppu_riu_pkg::FUNC_INC_Y, 3'($urandom),
                                       8'($urandom)));
               seq.push_back(make_item(ppu_riu_pkg::FUNC_COPY_HORIZ, 3'($urandom),
                                       8'($urandom)));
            end
         end else if (pick < 62) begin
            start = 8'($urandom);
            seq.push_back(make_item(ppu_riu_pkg::FUNC_REG_WRITE, ppu_riu_pkg::REG_OAM_ADDR,
                                    start));
            repeat ($urandom_range(1, 6))
               seq.push_back(make_item(ppu_riu_pkg::FUNC_REG_WRITE,
                                       ppu_riu_pkg::REG_OAM_DATA, 8'($urandom)));
            seq.push_back(make_item(ppu_riu_pkg::FUNC_REG_WRITE, ppu_riu_pkg::REG_OAM_ADDR,
                                    start));
            repeat ($urandom_range(1, 3))
               seq.push_back(make_item(ppu_riu_pkg::FUNC_REG_READ,
                                       ppu_riu_pkg::REG_OAM_DATA, 8'($urandom)));
         end else if (pick < 77) begin
            repeat ($urandom_range(1, 6)) begin
               case ($urandom_range(0, 4))
                  0: item = make_item(ppu_riu_pkg::FUNC_REG_READ, ppu_riu_pkg::REG_STATUS,
                                      8'($urandom));
                  1: item = make_item(ppu_riu_pkg::FUNC_VBLANK, 3'($urandom),
                                      8'($urandom));
                  2: item = make_item(ppu_riu_pkg::FUNC_PRERENDER, 3'($urandom),
                                      8'($urandom));
                  3: item = make_item(ppu_riu_pkg::FUNC_SET_HIT, 3'($urandom),
                                      8'($urandom));
                  default: item = make_item(ppu_riu_pkg::FUNC_SET_OVF, 3'($urandom),
                                            8'($urandom));
               endcase
               seq.push_back(item);
            end
         end else if (pick < 87) begin
            seq.push_back(make_item(ppu_riu_pkg::FUNC_REG_WRITE,
                                    $urandom_range(0, 1) ? ppu_riu_pkg::REG_CTRL
                                                         : ppu_riu_pkg::REG_MASK,
                                    8'($urandom)));
         end else begin
            repeat ($urandom_range(1, 4))
               seq.push_back(make_item(4'($urandom), 3'($urandom), 8'($urandom)));
         end

         foreach (seq[i]) begin
            send_item(seq[i], 1'b0, '0);
            if (seq[i].func <= ppu_riu_pkg::FUNC_SET_OVF) sent++;
         end
         seq.delete();
      end

      req_if.valid <= 1'b0;
      @(posedge clock);
      guard = 0;
      while (expect_q.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expect_q.size() != 0) begin
         fail_count++;
         $display("%0t ns missing responses: expected 0 outstanding actual %0d",
                  $time, expect_q.size());
      end
      if (fail_count == 0)
         $display("PASS ppu_register_interface_unit");
      else
         $display("FAIL ppu_register_interface_unit");
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("FAIL ppu_register_interface_unit");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/ppu_riu_pkg.sv
rtl/core/ppu_riu_req_if.sv
rtl/core/ppu_riu_rsp_if.sv
rtl/core/ppu_register_interface_unit.sv
rtl/core/ppu_riu_checker.sv
tb/sv/tb_top.sv
